/* rtl/b64d_pkg.sv */
// shared types, constants and the character classifier for the base64 decoder
package b64d_pkg;

  localparam logic [6:0] MISSING_CODE = 7'h7f;
  localparam logic [7:0] NOISE_CODE   = 8'h80;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_group;
  } out_item_t;

  // decoded group handed from the group stage to the result buffer
  typedef struct packed {
    logic [1:0] nbytes;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } grp_res_t;

  // 0..63 for alphabet, missing code for '=', noise flag in bit 7 otherwise
  function automatic logic [7:0] classify(input logic [7:0] c);
    logic [7:0] r;
    begin
      if (c >= "A" && c <= "Z") r = c - 8'd65;
      else if (c >= "a" && c <= "z") r = c - 8'd71;
      else if (c >= "0" && c <= "9") r = c + 8'd4;
      else if (c == "+") r = 8'd62;
      else if (c == "/") r = 8'd63;
      else if (c == "=") r = {1'b0, MISSING_CODE};
      else r = NOISE_CODE;
      return r;
    end
  endfunction

endpackage

/* rtl/base64_decoder_with_noise_skip_unit.sv */
// top level of the base64 decoder with noise skipping
//
//   channel | ports                         | payload
//   --------+-------------------------------+--------------------------------
//   input   | in_valid, in_stall, in_data   | text_char, end_of_stream
//   result  | out_valid, out_stall, out_data| data_byte, last_of_group
//
// one character request is taken per cycle unless in_stall is high; a group that
// completes loads up to three bytes into the result buffer, which drains one byte
// per cycle unless out_stall is high. a group that completes while bytes are still
// waiting parks in a pending register; input stalls only while that register is full.
// four characters give at most three bytes, so an unstalled stream runs at one
// character per cycle. synchronous reset empties the group and both buffers.
module base64_decoder_with_noise_skip_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  b64d_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output b64d_pkg::out_item_t out_data
);
  import b64d_pkg::*;

  grp_res_t   res;
  logic       in_fire;
  logic       out_fire;
  logic [7:0] bytes_r [3];
  logic [1:0] rem_r;
  logic [1:0] rem_nxt;
  logic [1:0] idx_r;
  logic [1:0] idx_nxt;
  grp_res_t   pend_r;
  logic       pend_vld_r;
  logic       pend_vld_nxt;
  logic       load_new;
  logic       act_free;
  logic       load_act;
  logic       pend_load;
  grp_res_t   act_src;

  assign out_valid = (rem_r != 2'd0);
  assign out_fire  = out_valid && !out_stall;
  assign in_stall  = pend_vld_r;
  assign in_fire   = in_valid && !in_stall;

  b64d_group u_group (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (in_fire),
    .item  (in_data),
    .res   (res)
  );

  // active buffer is free when empty or its last byte leaves this cycle
  assign load_new     = in_fire && (res.nbytes != 2'd0);
  assign act_free     = (rem_r == 2'd0) || (rem_r == 2'd1 && out_fire);
  assign load_act     = act_free && (pend_vld_r || load_new);
  assign pend_load    = load_new && !act_free;
  assign act_src      = pend_vld_r ? pend_r : res;
  assign pend_vld_nxt = pend_load || (pend_vld_r && !act_free);

  always_comb begin
    case (idx_r)
      2'd0:    out_data.data_byte = bytes_r[0];
      2'd1:    out_data.data_byte = bytes_r[1];
      default: out_data.data_byte = bytes_r[2];
    endcase
    out_data.last_of_group = (rem_r == 2'd1);
  end

  always_comb begin
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    if (load_act) begin
      rem_nxt = act_src.nbytes;
      idx_nxt = 2'd0;
    end else if (out_fire) begin
      rem_nxt = rem_r - 2'd1;
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r      <= 2'd0;
      idx_r      <= 2'd0;
      pend_vld_r <= 1'b0;
    end else begin
      rem_r      <= rem_nxt;
      idx_r      <= idx_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_act) begin
      bytes_r[0] <= act_src.b0;
      bytes_r[1] <= act_src.b1;
      bytes_r[2] <= act_src.b2;
    end
    if (pend_load) pend_r <= res;
  end

endmodule

/* rtl/b64d_group.sv */
// group collector: holds the first three codes of a group and decodes a finished group
module b64d_group (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  b64d_pkg::in_item_t item,
  output b64d_pkg::grp_res_t res
);
  import b64d_pkg::*;

  logic [6:0] codes_r [3];
  logic [1:0] fill_r;
  logic [1:0] fill_nxt;
  logic [7:0] code;
  logic       noise;
  logic       emit;
  logic [6:0] c [4];
  logic [5:0] v [4];
  logic [2:0] missing;

  assign code  = classify(item.text_char);
  assign noise = code[7];

  assign emit = (!noise && (fill_r == 2'd3 || item.end_of_stream)) ||
                (noise && item.end_of_stream && fill_r != 2'd0);

  // positions past the held ones take the new code once, then count as missing
  always_comb begin
    missing = 3'd0;
    for (int k = 0; k < 4; k++) begin
      if (k < 3 && 2'(k) < fill_r) c[k] = codes_r[k];
      else if (2'(k) == fill_r && !noise) c[k] = code[6:0];
      else c[k] = MISSING_CODE;
      v[k] = c[k][5:0];
      missing = missing + {2'b00, c[k][6]};
    end
  end

  always_comb begin
    res.b0 = {v[0], v[1][5:4]};
    res.b1 = {v[1][3:0], v[2][5:2]};
    res.b2 = {v[2][1:0], v[3]};
    if (!emit) res.nbytes = 2'd0;
    else if (missing == 3'd2) res.nbytes = 2'd1;
    else if (missing == 3'd1) res.nbytes = 2'd2;
    else res.nbytes = 2'd3;
  end

  always_comb begin
    if (emit) fill_nxt = 2'd0;
    else if (!noise) fill_nxt = fill_r + 2'd1;
    else fill_nxt = fill_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= 2'd0;
      codes_r[0] <= 7'd0;
      codes_r[1] <= 7'd0;
      codes_r[2] <= 7'd0;
    end else if (fire) begin
      fill_r <= fill_nxt;
      if (!noise && fill_r != 2'd3) codes_r[fill_r] <= code[6:0];
    end
  end

endmodule
